FILE: design/wcm_pkg.sv
// Shared constants and types for the wall column texture mapper.
`timescale 1ns / 1ps

package wcm_pkg;

	localparam int MAX_SCREEN_HEIGHT_DEF = 512;
	localparam int ROWS_PER_RESULT_DEF = 8;
	localparam int RESULT_LIMIT = 64;

	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

	localparam logic [8:0] TEX_WIDTH_RST = 9'd64;
	localparam logic [8:0] TEX_HEIGHT_RST = 9'd64;
	localparam logic [8:0] CELL_SIZE_RST = 9'd64;
	localparam logic [9:0] SCREEN_HEIGHT_RST = 10'd480;

	localparam int DVD_W = 37;
	localparam int DVS_W = 14;
	localparam int CNT_W = 6;
	localparam int SHORT_BITS = 25;
	localparam int STEP_W = 25;

	typedef struct packed {
		logic [11:0] column;
		logic [13:0] wall;
		logic [23:0] coord;
		logic [3:0]  texture;
		logic [8:0]  ceil_row;
		logic [9:0]  total;
		logic [8:0]  tw;
		logic [8:0]  th;
		logic [8:0]  cs;
		logic        tall;
		logic [12:0] half;
	} item_t;

	typedef struct packed {
		logic             go;
		logic [DVD_W-1:0] dvd;
		logic [DVS_W-1:0] dvs;
		logic [CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: design/wcm_front.sv
// Front end: configuration registers, input acceptance and column classification.
`timescale 1ns / 1ps

module wcm_front #(
	parameter int MAX_SCREEN_HEIGHT = wcm_pkg::MAX_SCREEN_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wcm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [11:0]                  column,
	input  logic [13:0]                  wall_height,
	input  logic [23:0]                  hit_x,
	input  logic [23:0]                  hit_y,
	input  logic                         vertical_hit,
	input  logic [3:0]                   texture_id,
	input  logic                         q_full,
	output logic                         q_push,
	output wcm_pkg::item_t               q_item
);

	logic [8:0]  tex_width_q;
	logic [8:0]  tex_height_q;
	logic [8:0]  cell_size_q;
	logic [9:0]  screen_height_q;

	logic [8:0]  tw;
	logic [8:0]  th;
	logic [8:0]  cs;
	logic [9:0]  hh;
	logic [13:0] wall;
	logic [14:0] diff;
	logic [8:0]  ceil_row;
	logic [11:0] tot;
	logic [13:0] over;
	logic        has_rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q <= wcm_pkg::TEX_WIDTH_RST;
			tex_height_q <= wcm_pkg::TEX_HEIGHT_RST;
			cell_size_q <= wcm_pkg::CELL_SIZE_RST;
			screen_height_q <= wcm_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wcm_pkg::REG_TEX_WIDTH: tex_width_q <= cfg_data[8:0];
				wcm_pkg::REG_TEX_HEIGHT: tex_height_q <= cfg_data[8:0];
				wcm_pkg::REG_CELL_SIZE: cell_size_q <= cfg_data[8:0];
				wcm_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [8:0] clamp_tex(input logic [8:0] v);
		if (v == 9'd0)
			return 9'd1;
		else if (v > 9'd256)
			return 9'd256;
		else
			return v;
	endfunction

	always_comb begin
		tw = clamp_tex(tex_width_q);
		th = clamp_tex(tex_height_q);
		cs = clamp_tex(cell_size_q);
		if (screen_height_q < 10'd8)
			hh = 10'd8;
		else if (screen_height_q > 10'(MAX_SCREEN_HEIGHT))
			hh = 10'(MAX_SCREEN_HEIGHT);
		else
			hh = screen_height_q;

		wall = (wall_height == 14'd0) ? 14'd1 : wall_height;
		diff = {5'b0, hh} - {1'b0, wall};
		if (!diff[14])
			ceil_row = 9'(diff[9:1]) + 9'd1;
		else if (diff == '1)
			ceil_row = 9'd1;
		else
			ceil_row = '0;

		tot = {2'b0, hh} - {2'b0, ceil_row, 1'b0};
		has_rows = !tot[11] && (tot != '0);
		over = wall - {4'b0, hh};

		q_item.column = column;
		q_item.wall = wall;
		q_item.coord = vertical_hit ? hit_y : hit_x;
		q_item.texture = texture_id;
		q_item.ceil_row = ceil_row;
		q_item.total = tot[9:0];
		q_item.tw = tw;
		q_item.th = th;
		q_item.cs = cs;
		q_item.tall = wall > {4'b0, hh};
		q_item.half = over[13:1];
	end

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full && has_rows;

endmodule

FILE: design/wcm_queue.sv
// Two-entry queue of classified column items between front and back.
`timescale 1ns / 1ps

module wcm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wcm_pkg::item_t push_item,
	input  logic           pop,
	output logic           head_valid,
	output wcm_pkg::item_t head_item,
	output logic           full
);

	wcm_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	assign head_valid = count_q != 2'd0;
	assign head_item = mem_q[rd_ptr_q];
	assign full = count_q == 2'd2;

endmodule

FILE: design/wcm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wcm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wcm_pkg::div_req_t req,
	output wcm_pkg::div_rsp_t rsp
);

	logic                          active_q;
	logic                          done_q;
	logic [wcm_pkg::CNT_W-1:0]     cnt_q;
	logic [wcm_pkg::DVD_W-1:0]     dvd_q;
	logic [wcm_pkg::DVS_W-1:0]     dvs_q;
	logic [wcm_pkg::DVS_W-1:0]     rem_q;
	logic [wcm_pkg::DVD_W-1:0]     quo_q;

	logic [wcm_pkg::DVS_W:0]       rem_sh;
	logic [wcm_pkg::DVS_W:0]       rem_sub;
	logic                          fits;

	always_comb begin
		rem_sh = {rem_q, dvd_q[wcm_pkg::DVD_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				active_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (active_q) begin
				cnt_q <= cnt_q - wcm_pkg::CNT_W'(1);
				if (cnt_q == wcm_pkg::CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= req.dvd;
			dvs_q <= req.dvs;
			rem_q <= '0;
			quo_q <= '0;
		end else if (active_q) begin
			dvd_q <= {dvd_q[wcm_pkg::DVD_W-2:0], 1'b0};
			rem_q <= fits ? rem_sub[wcm_pkg::DVS_W-1:0] : rem_sh[wcm_pkg::DVS_W-1:0];
			quo_q <= {quo_q[wcm_pkg::DVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;

endmodule

FILE: design/wcm_back.sv
// Back end: per-column divisions, texture row lanes and the result register.
`timescale 1ns / 1ps

module wcm_back #(
	parameter int ROWS_PER_RESULT = wcm_pkg::ROWS_PER_RESULT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  wcm_pkg::item_t    head_item,
	output logic              pop,
	output wcm_pkg::div_req_t div_req,
	input  wcm_pkg::div_rsp_t div_rsp,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [11:0]       out_column,
	output logic [8:0]        first_row,
	output logic [7:0]        texel_column,
	output logic [3:0]        out_texture,
	output logic [63:0]       texel_rows,
	output logic [3:0]        row_count,
	output logic              last
);

	localparam int ACC_W = wcm_pkg::STEP_W
		+ $clog2(wcm_pkg::RESULT_LIMIT * ROWS_PER_RESULT) + 1;
	localparam int TROW_W = ACC_W - 16;
	localparam int RES_W = $clog2(wcm_pkg::RESULT_LIMIT + 1);
	localparam int PAD_W = wcm_pkg::DVD_W - wcm_pkg::SHORT_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_INIT = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	localparam logic [1:0] OP_COL = 2'd0;
	localparam logic [1:0] OP_MOD = 2'd1;
	localparam logic [1:0] OP_STEP = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	logic [2:0]                  state_q;
	logic [1:0]                  op_q;
	wcm_pkg::item_t              ent_q;
	logic [32:0]                 prod_q;
	logic [20:0]                 hprod_q;
	logic [7:0]                  tcol_q;
	logic [wcm_pkg::STEP_W-1:0]  step_q;
	logic [wcm_pkg::STEP_W-1:0]  start_q;
	logic [ACC_W-1:0]            lane_q [ROWS_PER_RESULT];
	logic [ACC_W-1:0]            stepr_q;
	logic [9:0]                  rows_left_q;
	logic [9:0]                  row_idx_q;
	logic [RES_W-1:0]            nres_q;

	logic                        out_valid_q;
	logic [11:0]                 out_column_q;
	logic [8:0]                  first_row_q;
	logic [7:0]                  texel_column_q;
	logic [3:0]                  out_texture_q;
	logic [63:0]                 texel_rows_q;
	logic [3:0]                  row_count_q;
	logic                        last_q;

	logic [3:0]                  n;
	logic [63:0]                 packed_rows;
	logic [TROW_W-1:0]           trow;
	logic [8:0]                  th_m1;
	logic                        is_last;
	logic                        load;
	logic [9:0]                  row_sum;

	always_comb begin
		div_req.go = state_q == ST_ISSUE;
		unique case (op_q)
			OP_COL: begin
				div_req.dvd = {prod_q[32:8], {PAD_W{1'b0}}};
				div_req.dvs = wcm_pkg::DVS_W'(ent_q.cs);
				div_req.nbits = wcm_pkg::CNT_W'(wcm_pkg::SHORT_BITS);
			end
			OP_MOD: begin
				div_req.dvd = {div_rsp.quo[wcm_pkg::SHORT_BITS-1:0], {PAD_W{1'b0}}};
				div_req.dvs = wcm_pkg::DVS_W'(ent_q.tw);
				div_req.nbits = wcm_pkg::CNT_W'(wcm_pkg::SHORT_BITS);
			end
			OP_STEP: begin
				div_req.dvd = {ent_q.th, 16'b0, {PAD_W{1'b0}}};
				div_req.dvs = ent_q.wall;
				div_req.nbits = wcm_pkg::CNT_W'(wcm_pkg::SHORT_BITS);
			end
			default: begin
				div_req.dvd = {hprod_q, 16'b0};
				div_req.dvs = ent_q.wall;
				div_req.nbits = wcm_pkg::CNT_W'(wcm_pkg::DVD_W);
			end
		endcase
	end

	always_comb begin
		if (rows_left_q < 10'(ROWS_PER_RESULT))
			n = rows_left_q[3:0];
		else
			n = 4'(ROWS_PER_RESULT);
		th_m1 = ent_q.th - 9'd1;
		packed_rows = '0;
		trow = '0;
		for (int k = 0; k < ROWS_PER_RESULT; k++) begin
			trow = lane_q[k][ACC_W-1:16];
			if (4'(k) < n) begin
				if (trow > TROW_W'(th_m1))
					packed_rows[8*k +: 8] = th_m1[7:0];
				else
					packed_rows[8*k +: 8] = trow[7:0];
			end
		end
		is_last = (rows_left_q == 10'(n))
			|| (nres_q == RES_W'(wcm_pkg::RESULT_LIMIT - 1));
		load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		row_sum = 10'(ent_q.ceil_row) + row_idx_q;
	end

	assign pop = (state_q == ST_IDLE) && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_COL;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					op_q <= OP_COL;
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_rsp.done) begin
						unique case (op_q)
							OP_COL: begin
								op_q <= OP_MOD;
								state_q <= ST_ISSUE;
							end
							OP_MOD: begin
								op_q <= OP_STEP;
								state_q <= ST_ISSUE;
							end
							OP_STEP: begin
								if (ent_q.tall) begin
									op_q <= OP_START;
									state_q <= ST_ISSUE;
								end else begin
									state_q <= ST_INIT;
								end
							end
							default: state_q <= ST_INIT;
						endcase
					end
				end
				ST_INIT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load && is_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= head_item;
		if (state_q == ST_MUL) begin
			prod_q <= 33'(ent_q.coord) * 33'(ent_q.tw);
			hprod_q <= 21'(ent_q.half) * 21'(ent_q.th);
			start_q <= '0;
		end
		if (state_q == ST_WAIT && div_rsp.done) begin
			unique case (op_q)
				OP_COL: ;
				OP_MOD: tcol_q <= div_rsp.rem[7:0];
				OP_STEP: step_q <= div_rsp.quo[wcm_pkg::STEP_W-1:0];
				default: start_q <= div_rsp.quo[wcm_pkg::STEP_W-1:0];
			endcase
		end
		if (state_q == ST_INIT) begin
			for (int k = 0; k < ROWS_PER_RESULT; k++)
				lane_q[k] <= ACC_W'(start_q) + ACC_W'(step_q) * ACC_W'(k);
			stepr_q <= ACC_W'(step_q) * ACC_W'(ROWS_PER_RESULT);
			rows_left_q <= ent_q.total;
			row_idx_q <= '0;
			nres_q <= '0;
		end
		if (load) begin
			for (int k = 0; k < ROWS_PER_RESULT; k++)
				lane_q[k] <= lane_q[k] + stepr_q;
			rows_left_q <= rows_left_q - 10'(n);
			row_idx_q <= row_idx_q + 10'(n);
			nres_q <= nres_q + RES_W'(1);
			out_column_q <= ent_q.column;
			first_row_q <= row_sum[8:0];
			texel_column_q <= tcol_q;
			out_texture_q <= ent_q.texture;
			texel_rows_q <= packed_rows;
			row_count_q <= n;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_column = out_column_q;
	assign first_row = first_row_q;
	assign texel_column = texel_column_q;
	assign out_texture = out_texture_q;
	assign texel_rows = texel_rows_q;
	assign row_count = row_count_q;
	assign last = last_q;

endmodule

FILE: design/wall_column_texture_mapper_core.sv
// Top level of the wall column texture mapper.
`timescale 1ns / 1ps

// Usage: each input item describes one screen column (wall height, hit point,
// hit side, texture number) and is taken on in_valid and in_ready. The block
// returns the covered screen rows of that column as results of up to
// ROWS_PER_RESULT texture rows each, on out_valid and out_ready, with last set
// on the final result of the column. A column that covers no row gives no result.
// Items are classified on entry and held in a two-entry queue; the back end
// works on one column at a time. Per column it runs three 25-step divisions on
// one shared bit-serial divider, plus a 37-step one when the wall is taller
// than the screen. Once the divisions are done, results leave at one per cycle
// while the receiver is ready. Configuration writes take effect at once and are
// meant for idle periods. Reset empties the queue and the result register and
// loads the register defaults. A stalled receiver holds the current result; the
// back end waits and the queue fills before in_ready drops.

module wall_column_texture_mapper_core #(
	parameter int MAX_SCREEN_HEIGHT = wcm_pkg::MAX_SCREEN_HEIGHT_DEF,
	parameter int ROWS_PER_RESULT = wcm_pkg::ROWS_PER_RESULT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wcm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [11:0]                   column,
	input  logic [13:0]                   wall_height,
	input  logic [23:0]                   hit_x,
	input  logic [23:0]                   hit_y,
	input  logic                          vertical_hit,
	input  logic [3:0]                    texture_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [11:0]                   out_column,
	output logic [8:0]                    first_row,
	output logic [7:0]                    texel_column,
	output logic [3:0]                    out_texture,
	output logic [63:0]                   texel_rows,
	output logic [3:0]                    row_count,
	output logic                          last
);

	logic              q_full;
	logic              q_push;
	wcm_pkg::item_t    q_item;
	logic              q_pop;
	logic              head_valid;
	wcm_pkg::item_t    head_item;
	wcm_pkg::div_req_t div_req;
	wcm_pkg::div_rsp_t div_rsp;

	wcm_front #(
		.MAX_SCREEN_HEIGHT(MAX_SCREEN_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.column(column),
		.wall_height(wall_height),
		.hit_x(hit_x),
		.hit_y(hit_y),
		.vertical_hit(vertical_hit),
		.texture_id(texture_id),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(q_item)
	);

	wcm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(q_item),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_item(head_item),
		.full(q_full)
	);

	wcm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	wcm_back #(
		.ROWS_PER_RESULT(ROWS_PER_RESULT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(q_pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_column(out_column),
		.first_row(first_row),
		.texel_column(texel_column),
		.out_texture(out_texture),
		.texel_rows(texel_rows),
		.row_count(row_count),
		.last(last)
	);

	a_row_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_count != 4'd0) && (row_count <= 4'(ROWS_PER_RESULT)))
		else $error("Result row count out of range.");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("A result followed the last result of a column at once.");

	a_rows_continue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& (out_column == $past(out_column))
			&& (first_row == 9'($past(first_row) + 9'($past(row_count)))))
		else $error("Rows of a column did not continue in the next result.");

	a_div_idle_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !div_rsp.done && !div_req.go)
		else $error("Divider active while a new column was taken.");

endmodule
